// File: design/splm_pkg.sv
`default_nettype none

package splm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 62;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int ROOT_STEPS  = ROOT_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]    SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] MAG_MAX   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    localparam logic ACT_FRAME  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_SAVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic acc_frame;
        logic load_div;
        logic div_step;
        logic load_root;
        logic root_step;
        logic save_rms;
        logic publish;
        logic chan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: design/splm_ctrl.sv
`default_nettype none

module splm_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   action,
    output logic                  in_stall,
    input  splm_pkg::ctrl_status_t status,
    output splm_pkg::ctrl_cmd_t   cmd
);
    import splm_pkg::*;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 chan_reg, chan_next;
    logic                 in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            chan_reg  <= CHAN_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chan_reg  <= chan_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && action == ACT_REPORT && !status.count_zero)
                begin
                    chan_next  = CHAN_LEFT;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    state_next = ST_ROOT_LOAD;
                end
            end
            ST_ROOT_LOAD:
            begin
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(ROOT_STEPS - 1))
                begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE:
            begin
                if (chan_reg == CHAN_LEFT)
                begin
                    chan_next  = CHAN_RIGHT;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.chan = chan_reg;
        unique case (state_reg)
            ST_IDLE:      cmd.acc_frame = in_accept && action == ACT_FRAME;
            ST_LOAD:      cmd.load_div  = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_ROOT_LOAD: cmd.load_root = 1'b1;
            ST_ROOT:      cmd.root_step = 1'b1;
            ST_SAVE:      cmd.save_rms  = 1'b1;
            ST_DONE:      cmd.publish   = status.out_free;
            default:      cmd.chan      = chan_reg;
        endcase
    end

endmodule

`default_nettype wire

// File: design/splm_datapath.sv
`default_nettype none

module splm_datapath (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire signed [splm_pkg::SAMPLE_BITS-1:0] left_sample,
    input  wire signed [splm_pkg::SAMPLE_BITS-1:0] right_sample,
    input  splm_pkg::ctrl_cmd_t                    cmd,
    output splm_pkg::ctrl_status_t                 status,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic [splm_pkg::COUNT_BITS-1:0]        frames_seen,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       rms_left,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       rms_right,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       peak_left,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       peak_right
);
    import splm_pkg::*;

    // accumulators
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SUM_BITS-1:0]    sum_l_reg, sum_r_reg;
    logic [SAMPLE_BITS-1:0] peak_l_reg, peak_r_reg;
    logic [SQUARE_BITS-1:0] sq_l_reg, sq_r_reg;
    logic                   add_pend_reg;

    logic [SAMPLE_BITS-1:0] mag_l, mag_r;
    logic [SUM_BITS:0]      add_l, add_r;
    logic                   count_full;

    // shared divider and square root
    logic [SUM_BITS-1:0]    div_q_reg, div_q_next;
    logic [COUNT_BITS-1:0]  div_rem_reg, div_rem_next;
    logic [COUNT_BITS:0]    div_trial;
    logic                   div_ge;

    logic [SUM_BITS-1:0]    rad_reg, rad_next;
    logic [ROOT_BITS-1:0]   root_reg, root_next;
    logic [ROOT_BITS:0]     rrem_reg, rrem_next;
    logic [ROOT_BITS+2:0]   rrem_shift, rtrial;
    logic                   root_ge;
    logic [SAMPLE_BITS-1:0] root_clamped;

    logic [SAMPLE_BITS-1:0] rms_l_reg, rms_r_reg;

    // output register
    logic                   out_valid_reg;
    logic [COUNT_BITS-1:0]  o_count_reg;
    logic [SAMPLE_BITS-1:0] o_rms_l_reg, o_rms_r_reg, o_peak_l_reg, o_peak_r_reg;

    assign mag_l = left_sample[SAMPLE_BITS-1]  ? (~left_sample + 1'b1)  : left_sample;
    assign mag_r = right_sample[SAMPLE_BITS-1] ? (~right_sample + 1'b1) : right_sample;

    assign count_full = (count_reg == COUNT_MAX);
    assign add_l = {1'b0, sum_l_reg} + (SUM_BITS+1)'(sq_l_reg);
    assign add_r = {1'b0, sum_r_reg} + (SUM_BITS+1)'(sq_r_reg);

    assign status.count_zero = (count_reg == '0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_l_reg    <= '0;
            sum_r_reg    <= '0;
            peak_l_reg   <= '0;
            peak_r_reg   <= '0;
            add_pend_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            count_reg    <= '0;
            sum_l_reg    <= '0;
            sum_r_reg    <= '0;
            peak_l_reg   <= '0;
            peak_r_reg   <= '0;
            add_pend_reg <= 1'b0;
        end
        else
        begin
            add_pend_reg <= cmd.acc_frame && !count_full;
            if (cmd.acc_frame)
            begin
                if (mag_l > peak_l_reg)
                    peak_l_reg <= mag_l;
                if (mag_r > peak_r_reg)
                    peak_r_reg <= mag_r;
                if (!count_full)
                    count_reg <= count_reg + 1'b1;
            end
            // add the registered squares into the sums in the cycle after the frame
            if (add_pend_reg)
            begin
                sum_l_reg <= add_l[SUM_BITS] ? SUM_MAX : add_l[SUM_BITS-1:0];
                sum_r_reg <= add_r[SUM_BITS] ? SUM_MAX : add_r[SUM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_frame)
        begin
            sq_l_reg <= mag_l * mag_l;
            sq_r_reg <= mag_r * mag_r;
        end
    end

    // restoring division, one quotient bit per cycle
    assign div_trial = {div_rem_reg, div_q_reg[SUM_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, count_reg});

    always_comb
    begin
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;
        if (cmd.load_div)
        begin
            div_q_next   = (cmd.chan == CHAN_LEFT) ? sum_l_reg : sum_r_reg;
            div_rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_q_next   = {div_q_reg[SUM_BITS-2:0], div_ge};
            div_rem_next = div_ge ? COUNT_BITS'(div_trial - {1'b0, count_reg})
                                  : div_trial[COUNT_BITS-1:0];
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    assign rrem_shift = {rrem_reg, rad_reg[SUM_BITS-1 -: 2]};
    assign rtrial     = {1'b0, root_reg, 2'b01};
    assign root_ge    = (rrem_shift >= rtrial);

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rrem_next = rrem_reg;
        if (cmd.load_root)
        begin
            rad_next  = div_q_reg;
            root_next = '0;
            rrem_next = '0;
        end
        else if (cmd.root_step)
        begin
            rad_next  = {rad_reg[SUM_BITS-3:0], 2'b00};
            root_next = {root_reg[ROOT_BITS-2:0], root_ge};
            // the remainder never exceeds twice the root, so its top bits stay clear
            rrem_next = root_ge ? (ROOT_BITS+1)'(rrem_shift - rtrial)
                                : rrem_shift[ROOT_BITS:0];
        end
    end

    assign root_clamped = (root_reg > ROOT_BITS'(MAG_MAX)) ? MAG_MAX
                                                           : root_reg[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rrem_reg    <= rrem_next;
        if (cmd.save_rms)
        begin
            if (cmd.chan == CHAN_LEFT)
                rms_l_reg <= root_clamped;
            else
                rms_r_reg <= root_clamped;
        end
        if (cmd.publish)
        begin
            o_count_reg  <= count_reg;
            o_rms_l_reg  <= rms_l_reg;
            o_rms_r_reg  <= rms_r_reg;
            o_peak_l_reg <= peak_l_reg;
            o_peak_r_reg <= peak_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign frames_seen = o_count_reg;
    assign rms_left    = o_rms_l_reg;
    assign rms_right   = o_rms_r_reg;
    assign peak_left   = o_peak_l_reg;
    assign peak_right  = o_peak_r_reg;

endmodule

`default_nettype wire

// File: design/stereo_peak_rms_level_meter_top.sv
`default_nettype none

// Stereo peak/RMS level meter. Each item with action 0 is one stereo frame; frames are
// taken back to back while idle; the peaks and frame count update at once and the
// squares land in the 62-bit sums in the cycle after. An item with action 1 reports
// the window: if no frame was seen it is dropped, otherwise the input stalls while one
// shared divider (one quotient bit per cycle) and one square-root unit (one root bit
// per cycle) work through the left and then the right channel. The result goes to an
// output register, so frames are taken again while it waits; the next report waits only
// if that register is still full. The accumulators clear when the report is published.
module stereo_peak_rms_level_meter_top (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    action,
    input  wire signed [splm_pkg::SAMPLE_BITS-1:0] left_sample,
    input  wire signed [splm_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic [splm_pkg::COUNT_BITS-1:0]        frames_seen,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       rms_left,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       rms_right,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       peak_left,
    output logic [splm_pkg::SAMPLE_BITS-1:0]       peak_right
);
    import splm_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    splm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    splm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frames_seen  (frames_seen),
        .rms_left     (rms_left),
        .rms_right    (rms_right),
        .peak_left    (peak_left),
        .peak_right   (peak_right)
    );

endmodule

`default_nettype wire
